/* sv/mctt_pkg.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mctt_pkg
// Shared widths, codes, command and status types of the text terminal engine.
// ----------------------------------------------------------------------------
package mctt_pkg;

	localparam int CONSOLES_DEF = 8;
	localparam int MAX_ROWS_DEF = 50;
	localparam int COLUMNS_DEF  = 80;

	localparam int REQ_W  = 2;
	localparam int CON_W  = 3;
	localparam int CHAR_W = 8;
	localparam int ROW_W  = 6;
	localparam int COL_W  = 7;

	localparam logic [REQ_W-1:0] REQ_PUT  = 2'd0;
	localparam logic [REQ_W-1:0] REQ_GOTO = 2'd1;
	localparam logic [REQ_W-1:0] REQ_READ = 2'd2;

	localparam logic [CHAR_W-1:0] CH_BEL   = 8'h07;
	localparam logic [CHAR_W-1:0] CH_BS    = 8'h08;
	localparam logic [CHAR_W-1:0] CH_TAB   = 8'h09;
	localparam logic [CHAR_W-1:0] CH_LF    = 8'h0A;
	localparam logic [CHAR_W-1:0] CH_FF    = 8'h0C;
	localparam logic [CHAR_W-1:0] CH_CR    = 8'h0D;
	localparam logic [CHAR_W-1:0] CH_SPACE = 8'h20;

	localparam logic [ROW_W-1:0] NUM_ROWS_RST = 6'd25;

	typedef enum logic [1:0] {
		OP_NONE   = 2'd0,
		OP_READ   = 2'd1,
		OP_FILL   = 2'd2,
		OP_SCROLL = 2'd3
	} op_t;

	typedef enum logic [1:0] {
		CNT_ZERO   = 2'd0,
		CNT_SCROLL = 2'd1,
		CNT_LAST   = 2'd2
	} cnt_sel_t;

	typedef struct packed {
		logic     load;
		logic     decode;
		logic     cap_cell;
		logic     cnt_ld;
		cnt_sel_t cnt_sel;
		logic     fill_wr;
		logic     copy_rd;
		logic     copy_wr;
		logic     clr_wr;
		logic     out_load;
	} dp_cmd_t;

	typedef struct packed {
		op_t  op;
		logic rows_one;
		logic ccnt_last;
		logic rcnt_last;
		logic clr_last;
		logic out_free;
	} dp_status_t;

endpackage

/* sv/mctt_ifs.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mctt request and response channels
// Valid/ready channels carrying one request beat and one response beat.
// ----------------------------------------------------------------------------
interface mctt_req_if;
	logic                         valid;
	logic                         ready;
	logic [mctt_pkg::REQ_W-1:0]   req_type;
	logic [mctt_pkg::CON_W-1:0]   console;
	logic [mctt_pkg::CHAR_W-1:0]  data_char;
	logic [mctt_pkg::ROW_W-1:0]   row;
	logic [mctt_pkg::COL_W-1:0]   col;

	modport source (output valid, req_type, console, data_char, row, col, input ready);
	modport sink (input valid, req_type, console, data_char, row, col, output ready);
endinterface

interface mctt_rsp_if;
	logic                         valid;
	logic                         ready;
	logic [mctt_pkg::CHAR_W-1:0]  cell_char;
	logic [mctt_pkg::ROW_W-1:0]   cursor_row;
	logic [mctt_pkg::COL_W-1:0]   cursor_col;
	logic                         pass_valid;
	logic [mctt_pkg::CHAR_W-1:0]  pass_char;
	logic                         rejected;

	modport source (output valid, cell_char, cursor_row, cursor_col, pass_valid, pass_char,
		rejected, input ready);
	modport sink (input valid, cell_char, cursor_row, cursor_col, pass_valid, pass_char,
		rejected, output ready);
endinterface

/* sv/mctt_ctrl.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mctt_ctrl
// Sequencer: clearing pass, request decode, screen fill and scroll sweeps.
// ----------------------------------------------------------------------------
module mctt_ctrl (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 in_valid,
	output logic                 in_ready,
	output mctt_pkg::dp_cmd_t    cmd,
	input  mctt_pkg::dp_status_t st
);

	typedef enum logic [7:0] {
		ST_CLEAR   = 8'b0000_0001,
		ST_IDLE    = 8'b0000_0010,
		ST_DECODE  = 8'b0000_0100,
		ST_RD_WAIT = 8'b0000_1000,
		ST_FILL    = 8'b0001_0000,
		ST_COPY_RD = 8'b0010_0000,
		ST_COPY_WR = 8'b0100_0000,
		ST_DONE    = 8'b1000_0000
	} state_t;

	state_t state_q;
	state_t state_d;

	assign in_ready = (state_q == ST_IDLE);

	always_comb begin
		cmd     = '0;
		state_d = state_q;
		case (state_q)
			ST_CLEAR: begin
				cmd.clr_wr = 1'b1;
				if (st.clr_last) state_d = ST_IDLE;
			end
			ST_IDLE: begin
				if (in_valid) begin
					cmd.load = 1'b1;
					state_d  = ST_DECODE;
				end
			end
			ST_DECODE: begin
				cmd.decode = 1'b1;
				case (st.op)
					mctt_pkg::OP_READ: state_d = ST_RD_WAIT;
					mctt_pkg::OP_FILL: begin
						cmd.cnt_ld  = 1'b1;
						cmd.cnt_sel = mctt_pkg::CNT_ZERO;
						state_d     = ST_FILL;
					end
					mctt_pkg::OP_SCROLL: begin
						cmd.cnt_ld  = 1'b1;
						cmd.cnt_sel = mctt_pkg::CNT_SCROLL;
						state_d     = st.rows_one ? ST_FILL : ST_COPY_RD;
					end
					default: state_d = ST_DONE;
				endcase
			end
			ST_RD_WAIT: begin
				cmd.cap_cell = 1'b1;
				state_d      = ST_DONE;
			end
			ST_FILL: begin
				cmd.fill_wr = 1'b1;
				if (st.ccnt_last && st.rcnt_last) state_d = ST_DONE;
			end
			ST_COPY_RD: begin
				cmd.copy_rd = 1'b1;
				state_d     = ST_COPY_WR;
			end
			ST_COPY_WR: begin
				cmd.copy_wr = 1'b1;
				if (st.ccnt_last && st.rcnt_last) begin
					cmd.cnt_ld  = 1'b1;
					cmd.cnt_sel = mctt_pkg::CNT_LAST;
					state_d     = ST_FILL;
				end else begin
					state_d = ST_COPY_RD;
				end
			end
			ST_DONE: begin
				if (st.out_free) begin
					cmd.out_load = 1'b1;
					state_d      = ST_IDLE;
				end
			end
			default: state_d = ST_CLEAR;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_CLEAR;
		end else begin
			state_q <= state_d;
		end
	end

endmodule

/* sv/mctt_dp.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mctt_dp
// Cell memory, cursors, row-count register, sweep counters and result beat.
// ----------------------------------------------------------------------------
module mctt_dp #(
	parameter int CONSOLES = mctt_pkg::CONSOLES_DEF,
	parameter int MAX_ROWS = mctt_pkg::MAX_ROWS_DEF,
	parameter int COLUMNS  = mctt_pkg::COLUMNS_DEF
) (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            cfg_we,
	input  logic [mctt_pkg::ROW_W-1:0]      cfg_wdata,
	input  logic [mctt_pkg::REQ_W-1:0]      req_type,
	input  logic [mctt_pkg::CON_W-1:0]      console,
	input  logic [mctt_pkg::CHAR_W-1:0]     data_char,
	input  logic [mctt_pkg::ROW_W-1:0]      row,
	input  logic [mctt_pkg::COL_W-1:0]      col,
	input  mctt_pkg::dp_cmd_t               cmd,
	output mctt_pkg::dp_status_t            st,
	input  logic                            rsp_ready,
	output logic                            rsp_valid,
	output logic [mctt_pkg::CHAR_W-1:0]     cell_char,
	output logic [mctt_pkg::ROW_W-1:0]      cursor_row,
	output logic [mctt_pkg::COL_W-1:0]      cursor_col,
	output logic                            pass_valid,
	output logic [mctt_pkg::CHAR_W-1:0]     pass_char,
	output logic                            rejected
);

	localparam int ROW_W     = mctt_pkg::ROW_W;
	localparam int COL_W     = mctt_pkg::COL_W;
	localparam int CON_W     = mctt_pkg::CON_W;
	localparam int CHAR_W    = mctt_pkg::CHAR_W;
	localparam int TOTAL     = CONSOLES * MAX_ROWS * COLUMNS;
	localparam int ADDR_W    = (TOTAL > 1) ? $clog2(TOTAL) : 1;
	localparam int CON_IDX_W = (CONSOLES > 1) ? $clog2(CONSOLES) : 1;

	localparam logic [ROW_W:0]       MAXR_L   = (ROW_W + 1)'(MAX_ROWS);
	localparam logic [COL_W:0]       COLS_L   = (COL_W + 1)'(COLUMNS);
	localparam logic [COL_W-1:0]     COL_LAST = COL_W'(COLUMNS - 1);
	localparam logic [CON_W+1:0]     CONS_L   = (CON_W + 2)'(CONSOLES);
	localparam logic [ADDR_W-1:0]    CLR_LAST = ADDR_W'(TOTAL - 1);

	function automatic logic [ADDR_W-1:0] cell_addr(
		input logic [CON_IDX_W-1:0] ci,
		input logic [ROW_W-1:0]     r,
		input logic [COL_W-1:0]     c
	);
		cell_addr = ADDR_W'((int'(ci) * MAX_ROWS + int'(r)) * COLUMNS + int'(c));
	endfunction

	logic [CHAR_W-1:0]    mem [TOTAL];
	logic [CHAR_W-1:0]    rdata_q;

	logic [ROW_W-1:0]     num_rows_q;
	logic [ROW_W-1:0]     cur_rows_q [CONSOLES];
	logic [COL_W-1:0]     cur_cols_q [CONSOLES];

	logic [mctt_pkg::REQ_W-1:0] req_q;
	logic [CON_W-1:0]     con_q;
	logic [CHAR_W-1:0]    ch_q;
	logic [ROW_W-1:0]     row_q;
	logic [COL_W-1:0]     col_q;

	logic [ROW_W-1:0]     rcnt_q;
	logic [COL_W-1:0]     ccnt_q;
	logic [ADDR_W-1:0]    clr_q;

	logic [CHAR_W-1:0]    res_cell_q;
	logic [ROW_W-1:0]     res_row_q;
	logic [COL_W-1:0]     res_col_q;
	logic                 res_pv_q;
	logic [CHAR_W-1:0]    res_pc_q;
	logic                 res_rej_q;
	logic                 out_valid_q;

	logic [CON_IDX_W-1:0] con_idx;
	logic [ROW_W-1:0]     cur_r;
	logic [COL_W-1:0]     cur_c;
	logic [ROW_W:0]       rows_w;
	logic [ROW_W-1:0]     rows_m1;
	logic [ROW_W:0]       row_adv;
	logic [COL_W:0]       col_adv;
	logic                 scroll_need;
	logic                 col_wrap;
	logic                 oor;
	logic                 con_bad;

	logic [ROW_W-1:0]     nr;
	logic [COL_W-1:0]     nc;
	logic                 pv;
	logic [CHAR_W-1:0]    pc;
	logic                 rej;
	mctt_pkg::op_t        op;
	logic                 dec_wr;
	logic [ADDR_W-1:0]    dec_waddr;
	logic [CHAR_W-1:0]    dec_wdata;

	logic                 mem_we;
	logic [ADDR_W-1:0]    waddr;
	logic [CHAR_W-1:0]    wdata;
	logic                 mem_re;
	logic [ADDR_W-1:0]    raddr;

	assign con_idx = CON_IDX_W'(con_q);
	assign cur_r   = cur_rows_q[con_idx];
	assign cur_c   = cur_cols_q[con_idx];
	assign con_bad = {2'b00, con_q} >= CONS_L;

	always_comb begin
		rows_w = {1'b0, num_rows_q};
		if (num_rows_q == '0) begin
			rows_w = (ROW_W + 1)'(1);
		end else if (rows_w > MAXR_L) begin
			rows_w = MAXR_L;
		end
	end

	assign rows_m1     = ROW_W'(rows_w - 1'b1);
	assign row_adv     = {1'b0, cur_r} + 1'b1;
	assign col_adv     = {1'b0, cur_c} + 1'b1;
	assign scroll_need = row_adv >= rows_w;
	assign col_wrap    = col_adv >= COLS_L;
	assign oor         = ({1'b0, row_q} >= rows_w) || ({1'b0, col_q} >= COLS_L);

	always_comb begin
		nr        = cur_r;
		nc        = cur_c;
		pv        = 1'b0;
		pc        = '0;
		rej       = 1'b0;
		op        = mctt_pkg::OP_NONE;
		dec_wr    = 1'b0;
		dec_waddr = cell_addr(con_idx, cur_r, cur_c);
		dec_wdata = ch_q;
		if (con_bad) begin
			rej = 1'b1;
		end else begin
			case (req_q)
				mctt_pkg::REQ_PUT: begin
					case (ch_q)
						mctt_pkg::CH_FF: begin
							nr = '0;
							nc = '0;
							op = mctt_pkg::OP_FILL;
						end
						mctt_pkg::CH_CR: nc = '0;
						mctt_pkg::CH_LF: begin
							if (scroll_need) begin
								nr = rows_m1;
								op = mctt_pkg::OP_SCROLL;
							end else begin
								nr = row_adv[ROW_W-1:0];
							end
						end
						mctt_pkg::CH_BS: begin
							if (cur_c != '0) begin
								nc        = cur_c - 1'b1;
								dec_wr    = 1'b1;
								dec_waddr = cell_addr(con_idx, cur_r, nc);
								dec_wdata = mctt_pkg::CH_SPACE;
							end else begin
								pv = 1'b1;
								pc = mctt_pkg::CH_BS;
							end
						end
						mctt_pkg::CH_TAB: begin
							pv = 1'b1;
							pc = mctt_pkg::CH_SPACE;
						end
						mctt_pkg::CH_BEL: begin
							pv = 1'b1;
							pc = mctt_pkg::CH_BEL;
						end
						default: begin
							dec_wr = 1'b1;
							if (col_wrap) begin
								nc = '0;
								if (scroll_need) begin
									nr = rows_m1;
									op = mctt_pkg::OP_SCROLL;
								end else begin
									nr = row_adv[ROW_W-1:0];
								end
							end else begin
								nc = col_adv[COL_W-1:0];
							end
						end
					endcase
				end
				mctt_pkg::REQ_GOTO: begin
					if (oor) begin
						rej = 1'b1;
					end else begin
						nr = row_q;
						nc = col_q;
					end
				end
				mctt_pkg::REQ_READ: begin
					if (oor) begin
						rej = 1'b1;
					end else begin
						op = mctt_pkg::OP_READ;
					end
				end
				default: ;
			endcase
		end
	end

	always_comb begin
		mem_we = 1'b0;
		waddr  = clr_q;
		wdata  = mctt_pkg::CH_SPACE;
		if (cmd.clr_wr) begin
			mem_we = 1'b1;
		end else if (cmd.fill_wr) begin
			mem_we = 1'b1;
			waddr  = cell_addr(con_idx, rcnt_q, ccnt_q);
		end else if (cmd.copy_wr) begin
			mem_we = 1'b1;
			waddr  = cell_addr(con_idx, ROW_W'(rcnt_q - 1'b1), ccnt_q);
			wdata  = rdata_q;
		end else if (cmd.decode && dec_wr) begin
			mem_we = 1'b1;
			waddr  = dec_waddr;
			wdata  = dec_wdata;
		end
	end

	assign mem_re = cmd.copy_rd || (cmd.decode && (op == mctt_pkg::OP_READ));
	assign raddr  = cmd.copy_rd ? cell_addr(con_idx, rcnt_q, ccnt_q)
		: cell_addr(con_idx, row_q, col_q);

	always_ff @(posedge clk) begin
		if (mem_we) mem[waddr] <= wdata;
		if (mem_re) rdata_q <= mem[raddr];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			num_rows_q <= mctt_pkg::NUM_ROWS_RST;
			for (int i = 0; i < CONSOLES; i++) begin
				cur_rows_q[i] <= '0;
				cur_cols_q[i] <= '0;
			end
		end else begin
			if (cfg_we) num_rows_q <= cfg_wdata;
			if (cmd.decode && !con_bad) begin
				cur_rows_q[con_idx] <= nr;
				cur_cols_q[con_idx] <= nc;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			req_q <= req_type;
			con_q <= console;
			ch_q  <= data_char;
			row_q <= row;
			col_q <= col;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rcnt_q <= '0;
			ccnt_q <= '0;
			clr_q  <= '0;
		end else begin
			if (cmd.clr_wr) clr_q <= clr_q + 1'b1;
			if (cmd.cnt_ld) begin
				ccnt_q <= '0;
				case (cmd.cnt_sel)
					mctt_pkg::CNT_ZERO:   rcnt_q <= '0;
					mctt_pkg::CNT_SCROLL: rcnt_q <= (rows_w == (ROW_W + 1)'(1)) ? '0
						: ROW_W'(1);
					mctt_pkg::CNT_LAST:   rcnt_q <= rows_m1;
					default:              rcnt_q <= '0;
				endcase
			end else if (cmd.fill_wr || cmd.copy_wr) begin
				if (ccnt_q == COL_LAST) begin
					ccnt_q <= '0;
					rcnt_q <= rcnt_q + 1'b1;
				end else begin
					ccnt_q <= ccnt_q + 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.decode) begin
			res_cell_q <= '0;
			res_row_q  <= con_bad ? '0 : nr;
			res_col_q  <= con_bad ? '0 : nc;
			res_pv_q   <= pv;
			res_pc_q   <= pc;
			res_rej_q  <= rej;
		end else if (cmd.cap_cell) begin
			res_cell_q <= rdata_q;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (cmd.out_load) begin
			out_valid_q <= 1'b1;
		end else if (rsp_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.out_load) begin
			cell_char  <= res_cell_q;
			cursor_row <= res_row_q;
			cursor_col <= res_col_q;
			pass_valid <= res_pv_q;
			pass_char  <= res_pc_q;
			rejected   <= res_rej_q;
		end
	end

	assign rsp_valid = out_valid_q;

	assign st.op        = op;
	assign st.rows_one  = (rows_w == (ROW_W + 1)'(1));
	assign st.ccnt_last = (ccnt_q == COL_LAST);
	assign st.rcnt_last = (rcnt_q == rows_m1);
	assign st.clr_last  = (clr_q == CLR_LAST);
	assign st.out_free  = !out_valid_q || rsp_ready;

	a_out_load_free: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.out_load |-> (!out_valid_q || rsp_ready))
		else $error("result loaded over an untaken beat");

	a_sweep_in_rows: assert property (@(posedge clk) disable iff (!arst_n)
		(cmd.fill_wr || cmd.copy_wr) |-> ({1'b0, rcnt_q} < rows_w))
		else $error("sweep row beyond rows in use");

	a_one_writer: assert property (@(posedge clk) disable iff (!arst_n)
		$onehot0({cmd.clr_wr, cmd.fill_wr, cmd.copy_wr, cmd.decode && dec_wr}))
		else $error("more than one cell write source");

	a_cursor_col_range: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.decode |=> ({1'b0, res_col_q} < COLS_L))
		else $error("cursor column out of range");

endmodule

/* sv/multi_console_text_terminal.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// multi_console_text_terminal
// Character terminal engine for several virtual text screens with cursors.
// ----------------------------------------------------------------------------
// One request beat is taken at a time and gives one response beat. After
// reset the cell memory is swept to spaces, one cell a cycle, over all
// CONSOLES*MAX_ROWS*COLUMNS cells (32000 at the defaults); requests wait
// until it ends, the row-count register can be written meanwhile. A request
// is then decoded; a read waits for the cell memory, a form feed fills the
// rows in use with spaces, and a scroll by line feed or line wrap copies
// each row in use up one row, with a read then a write per cell on the
// memory's single read and write ports, then fills the last row with spaces.
// A new request is accepted while the previous response still waits.
module multi_console_text_terminal #(
	parameter int CONSOLES = mctt_pkg::CONSOLES_DEF,
	parameter int MAX_ROWS = mctt_pkg::MAX_ROWS_DEF,
	parameter int COLUMNS  = mctt_pkg::COLUMNS_DEF
) (
	input  logic                       clk,
	input  logic                       arst_n,
	mctt_req_if.sink                   req,
	mctt_rsp_if.source                 rsp,
	input  logic                       cfg_we,
	input  logic [mctt_pkg::ROW_W-1:0] cfg_wdata
);

	mctt_pkg::dp_cmd_t    cmd;
	mctt_pkg::dp_status_t st;
	logic                 in_ready;

	assign req.ready = in_ready;

	mctt_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (req.valid),
		.in_ready (in_ready),
		.cmd      (cmd),
		.st       (st)
	);

	mctt_dp #(
		.CONSOLES (CONSOLES),
		.MAX_ROWS (MAX_ROWS),
		.COLUMNS  (COLUMNS)
	) u_dp (
		.clk        (clk),
		.arst_n     (arst_n),
		.cfg_we     (cfg_we),
		.cfg_wdata  (cfg_wdata),
		.req_type   (req.req_type),
		.console    (req.console),
		.data_char  (req.data_char),
		.row        (req.row),
		.col        (req.col),
		.cmd        (cmd),
		.st         (st),
		.rsp_ready  (rsp.ready),
		.rsp_valid  (rsp.valid),
		.cell_char  (rsp.cell_char),
		.cursor_row (rsp.cursor_row),
		.cursor_col (rsp.cursor_col),
		.pass_valid (rsp.pass_valid),
		.pass_char  (rsp.pass_char),
		.rejected   (rsp.rejected)
	);

endmodule
